### rtl/trr_pkg.sv
`default_nettype none

package trr_pkg;

  // Field widths
  localparam int unsigned RAW_W      = 12;
  localparam int unsigned TEMP_W     = 14;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned OFFSET_W   = 9;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned RATE_W     = 16;

  // Stream word widths
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 48;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_READ_INTERVAL = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_BEAN_OFFSET   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_ENV_OFFSET    = 2'd2;

  localparam logic [INTERVAL_W-1:0] READ_INTERVAL_RESET = 16'd250;

  // History
  localparam int unsigned DEFAULT_HISTORY_DEPTH = 16;
  localparam int unsigned MIN_FILL              = 3;

  // Rate scaling: quarter degrees per millisecond to per minute
  localparam int unsigned MS_PER_S     = 1000;
  localparam int unsigned S_PER_MIN    = 60;
  localparam int unsigned RATE_SCALE   = MS_PER_S * S_PER_MIN;
  localparam int unsigned SCALE_W      = 16;
  localparam logic [SCALE_W-1:0] RATE_SCALE_C = SCALE_W'(RATE_SCALE);

  // Temperature difference magnitude and scaled dividend
  localparam int unsigned DIFF_W     = TEMP_W + 1;
  localparam int unsigned DIVIDEND_W = DIFF_W + SCALE_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W);

  // Saturation limits
  localparam logic [DIVIDEND_W-1:0] RATE_POS_LIMIT = DIVIDEND_W'(32767);
  localparam logic [DIVIDEND_W-1:0] RATE_NEG_LIMIT = DIVIDEND_W'(32768);
  localparam logic [RATE_W-1:0]     RATE_MAX       = 16'h7fff;
  localparam logic [RATE_W-1:0]     RATE_MIN       = 16'h8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } trr_state_e;

endpackage

`default_nettype wire

### rtl/trr_ring.sv
`default_nettype none

module trr_ring #(
  parameter int unsigned DEPTH = trr_pkg::DEFAULT_HISTORY_DEPTH,
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [IDX_W-1:0]            waddr_i,
  input  wire logic [trr_pkg::TEMP_W-1:0]  wtemp_i,
  input  wire logic [trr_pkg::TIME_W-1:0]  wtime_i,
  input  wire logic [IDX_W-1:0]            raddr_new_i,
  input  wire logic [IDX_W-1:0]            raddr_old_i,
  output logic      [trr_pkg::TEMP_W-1:0]  new_temp_o,
  output logic      [trr_pkg::TIME_W-1:0]  new_time_o,
  output logic      [trr_pkg::TEMP_W-1:0]  old_temp_o,
  output logic      [trr_pkg::TIME_W-1:0]  old_time_o
);
  import trr_pkg::*;

  logic [TEMP_W-1:0] temp_mem [DEPTH];
  logic [TIME_W-1:0] time_mem [DEPTH];

  // Write the newest entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      temp_mem[waddr_i] <= wtemp_i;
      time_mem[waddr_i] <= wtime_i;
    end
  end

  // Read newest and oldest entries, registered
  always_ff @(posedge clk_i) begin
    new_temp_o <= temp_mem[raddr_new_i];
    new_time_o <= time_mem[raddr_new_i];
    old_temp_o <= temp_mem[raddr_old_i];
    old_time_o <= time_mem[raddr_old_i];
  end

endmodule

`default_nettype wire

### rtl/trr_div.sv
`default_nettype none

module trr_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [trr_pkg::DIVIDEND_W-1:0]  dividend_i,
  input  wire logic [trr_pkg::TIME_W-1:0]      divisor_i,
  output logic                                 done_o,
  output logic      [trr_pkg::DIVIDEND_W-1:0]  quotient_o
);
  import trr_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [TIME_W-1:0]     rem_q, rem_d;
  logic [TIME_W-1:0]     dsr_q, dsr_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [TIME_W:0]       shifted;
  logic [TIME_W:0]       trial;

  // One quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem_q, quo_q[DIVIDEND_W-1]};
    trial   = shifted - {1'b0, dsr_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    quo_d   = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIVIDEND_W - 1);
      rem_d  = '0;
      dsr_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (trial[TIME_W]) begin
        rem_d = shifted[TIME_W-1:0];
      end else begin
        rem_d = trial[TIME_W-1:0];
      end
      quo_d = {quo_q[DIVIDEND_W-2:0], ~trial[TIME_W]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

### rtl/thermocouple_rate_of_rise_top.sv
`default_nettype none

// Thermocouple rate-of-rise: each input word carries bean and environment
// readings in quarter degrees, their valid flags and a millisecond time; each
// produces exactly one result word with the accept flags, the calibrated (or
// raw) temperatures and the rate of rise in quarter degrees per minute over
// up to the last HISTORY_DEPTH valid readings. A reading taken with both flags
// set, once the history holds at least three entries with a nonzero time span,
// passes a ring read, a multiply, the 31 steps of the bit-serial restoring
// divider and the taking of its quotient, then the result load and the return
// to idle. With fewer than three entries it skips the multiply and divider,
// with a zero span the divider, and other readings go straight to the result
// load. A stalled result port holds the block before the result load; a new
// reading is accepted only in idle. The rate is kept between readings and
// reported unchanged when the history does not change.
// The history ring needs no clearing after reset: a fill count guards it.
module thermocouple_rate_of_rise_top #(
  parameter int unsigned HISTORY_DEPTH = trr_pkg::DEFAULT_HISTORY_DEPTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration
  input  wire logic                            cfg_we_i,
  input  wire logic [trr_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [trr_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // input stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // fields from bit 0: bean_raw[11:0], bean_ok, env_raw[11:0], env_ok,
  // now_ms[31:0], zero fill
  input  wire logic [trr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // output stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // fields from bit 0: accepted, both_ok, bean_temp[13:0], env_temp[13:0],
  // rise_rate[15:0], zero fill
  output logic      [trr_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import trr_pkg::*;

  localparam int unsigned IDX_W  = $clog2(HISTORY_DEPTH);
  localparam int unsigned FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SUM_W  = FILL_W + 1;

  // Configuration registers
  logic [INTERVAL_W-1:0] interval_q;
  logic [OFFSET_W-1:0]   bean_off_q;
  logic [OFFSET_W-1:0]   env_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= READ_INTERVAL_RESET;
      bean_off_q <= '0;
      env_off_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_IDX_READ_INTERVAL: interval_q <= cfg_wdata_i;
        CFG_IDX_BEAN_OFFSET:   bean_off_q <= cfg_wdata_i[OFFSET_W-1:0];
        CFG_IDX_ENV_OFFSET:    env_off_q  <= cfg_wdata_i[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Input fields
  logic [RAW_W-1:0]  bean_raw;
  logic              bean_ok;
  logic [RAW_W-1:0]  env_raw;
  logic              env_ok;
  logic [TIME_W-1:0] now_ms;

  assign bean_raw = s_axis_tdata[11:0];
  assign bean_ok  = s_axis_tdata[12];
  assign env_raw  = s_axis_tdata[24:13];
  assign env_ok   = s_axis_tdata[25];
  assign now_ms   = s_axis_tdata[57:26];

  trr_state_e state_q, state_d;

  logic              in_accept;
  logic              take;
  logic              take_both;
  logic [TIME_W-1:0] last_ms_q;
  logic [TIME_W-1:0] elapsed;
  logic [TEMP_W-1:0] bean_cal;
  logic [TEMP_W-1:0] env_cal;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign elapsed   = now_ms - last_ms_q;
  assign take      = elapsed >= {{(TIME_W-INTERVAL_W){1'b0}}, interval_q};
  assign take_both = take && bean_ok && env_ok;
  assign bean_cal  = {2'b00, bean_raw} + {{(TEMP_W-OFFSET_W){bean_off_q[OFFSET_W-1]}}, bean_off_q};
  assign env_cal   = {2'b00, env_raw} + {{(TEMP_W-OFFSET_W){env_off_q[OFFSET_W-1]}}, env_off_q};

  // History bookkeeping
  logic [IDX_W-1:0]  slot_q;
  logic [FILL_W-1:0] fill_q;
  logic              ring_we;

  assign ring_we = in_accept && take_both;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_ms_q <= '0;
      slot_q    <= '0;
      fill_q    <= '0;
    end else if (in_accept && take) begin
      last_ms_q <= now_ms;
      if (take_both) begin
        if (slot_q == IDX_W'(HISTORY_DEPTH - 1)) begin
          slot_q <= '0;
        end else begin
          slot_q <= slot_q + 1'b1;
        end
        if (fill_q < FILL_W'(HISTORY_DEPTH)) begin
          fill_q <= fill_q + 1'b1;
        end
      end
    end
  end

  // Newest and oldest ring addresses
  logic [IDX_W-1:0] raddr_new;
  logic [IDX_W-1:0] raddr_old;
  logic [SUM_W-1:0] old_sum;

  always_comb begin
    if (slot_q == '0) begin
      raddr_new = IDX_W'(HISTORY_DEPTH - 1);
    end else begin
      raddr_new = slot_q - 1'b1;
    end
    old_sum = SUM_W'(slot_q) + SUM_W'(HISTORY_DEPTH) - SUM_W'(fill_q);
    if (old_sum >= SUM_W'(HISTORY_DEPTH)) begin
      old_sum = old_sum - SUM_W'(HISTORY_DEPTH);
    end
    raddr_old = old_sum[IDX_W-1:0];
  end

  logic [TEMP_W-1:0] new_temp;
  logic [TIME_W-1:0] new_time;
  logic [TEMP_W-1:0] old_temp;
  logic [TIME_W-1:0] old_time;

  trr_ring #(
    .DEPTH (HISTORY_DEPTH),
    .IDX_W (IDX_W)
  ) u_ring (
    .clk_i       (clk_i),
    .we_i        (ring_we),
    .waddr_i     (slot_q),
    .wtemp_i     (bean_cal),
    .wtime_i     (now_ms),
    .raddr_new_i (raddr_new),
    .raddr_old_i (raddr_old),
    .new_temp_o  (new_temp),
    .new_time_o  (new_time),
    .old_temp_o  (old_temp),
    .old_time_o  (old_time)
  );

  // Scale the temperature difference and start the divider
  logic [DIFF_W-1:0]     diff;
  logic [DIFF_W-1:0]     diff_mag;
  logic [DIVIDEND_W-1:0] scaled;
  logic [TIME_W-1:0]     span;
  logic                  div_start;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] quotient;

  assign diff     = {new_temp[TEMP_W-1], new_temp} - {old_temp[TEMP_W-1], old_temp};
  assign diff_mag = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
  assign scaled   = diff_mag * RATE_SCALE_C;
  assign span     = new_time - old_time;

  trr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (scaled),
    .divisor_i  (span),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Next state
  logic out_free;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = take_both ? ST_READ : ST_DONE;
        end
      end
      ST_READ: begin
        state_d = (fill_q < FILL_W'(MIN_FILL)) ? ST_DONE : ST_MUL;
      end
      ST_MUL: begin
        state_d = (span == '0) ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // State outputs
  assign s_axis_tready = (state_q == ST_IDLE);
  assign div_start     = (state_q == ST_MUL) && (span != '0);

  // Hold the fields of the current word
  logic              acc_q;
  logic              both_q;
  logic [TEMP_W-1:0] bean_t_q;
  logic [TEMP_W-1:0] env_t_q;
  logic              neg_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      acc_q  <= take;
      both_q <= take_both;
      if (take_both) begin
        bean_t_q <= bean_cal;
        env_t_q  <= env_cal;
      end else if (take) begin
        bean_t_q <= {2'b00, bean_raw};
        env_t_q  <= {2'b00, env_raw};
      end else begin
        bean_t_q <= '0;
        env_t_q  <= '0;
      end
    end
    if (state_q == ST_MUL) begin
      neg_q <= diff[DIFF_W-1];
    end
  end

  // Rate kept across words, cleared on a zero time span, saturated on divider completion
  logic [RATE_W-1:0] rate_q;
  logic [RATE_W-1:0] rate_sat;

  always_comb begin
    if (neg_q) begin
      if (quotient > RATE_NEG_LIMIT) begin
        rate_sat = RATE_MIN;
      end else begin
        rate_sat = ~quotient[RATE_W-1:0] + 1'b1;
      end
    end else if (quotient > RATE_POS_LIMIT) begin
      rate_sat = RATE_MAX;
    end else begin
      rate_sat = quotient[RATE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= '0;
    end else if ((state_q == ST_MUL) && (span == '0)) begin
      rate_q <= '0;
    end else if ((state_q == ST_DIV) && div_done) begin
      rate_q <= rate_sat;
    end
  end

  // Output register
  logic out_load;

  assign out_load = (state_q == ST_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_axis_tdata <= {{(OUT_DATA_W-46){1'b0}}, rate_q, env_t_q, bean_t_q, both_q, acc_q};
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(HISTORY_DEPTH))
    else $error("history fill count beyond depth");

  a_fill_moves_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> $past(ring_we))
    else $error("fill count changed without a history write");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide state");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("result word loaded outside the done state");

endmodule

`default_nettype wire

### tb/tb_thermocouple_rate_of_rise_top.sv
module tb_thermocouple_rate_of_rise_top;
  timeunit 1ns;
  timeprecision 1ps;

  import trr_pkg::*;

  localparam int unsigned DEPTH       = DEFAULT_HISTORY_DEPTH;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYC  = 100;
  localparam int unsigned REPORT_MAX  = 10;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_UNUSED = 2'd3;

  // Highest field first, so bean_raw lands in the lowest bits of the word
  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              env_ok;
    logic [RAW_W-1:0]  env_raw;
    logic              bean_ok;
    logic [RAW_W-1:0]  bean_raw;
  } reading_t;

  typedef struct packed {
    logic                     accepted;
    logic                     both_ok;
    logic signed [TEMP_W-1:0] bean_temp;
    logic signed [TEMP_W-1:0] env_temp;
    logic signed [RATE_W-1:0] rise_rate;
  } roast_sample_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Readings waiting to be sent and samples waiting to come back
  reading_t      reading_q[$];
  roast_sample_t sample_q[$];

  // Mirror of the block's registers and history
  logic [INTERVAL_W-1:0] cfg_interval = READ_INTERVAL_RESET;
  int                    cfg_bean_ofs = 0;
  int                    cfg_env_ofs  = 0;
  int                    hist_temp[DEPTH];
  logic [TIME_W-1:0]     hist_time[DEPTH];
  int unsigned           hist_wr      = 0;
  int unsigned           hist_fill    = 0;
  logic [TIME_W-1:0]     last_take_ms = '0;

  logic [TIME_W-1:0] stamp_ms  = '0;
  int                walk_temp = 2000;
  bit                no_gaps   = 1'b0;
  int unsigned       fault_cnt = 0;
  int unsigned       cycle_cnt = 0;

  thermocouple_rate_of_rise_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Rate over the history window, quarter degrees per minute, saturated
  function automatic logic signed [RATE_W-1:0] window_rate();
    int unsigned       oldest;
    int unsigned       newest;
    logic [TIME_W-1:0] span;
    longint            span_l;
    longint            dtemp;
    longint            q;
    if (hist_fill < 3) return '0;
    oldest = (hist_wr + DEPTH - hist_fill) % DEPTH;
    newest = (hist_wr + DEPTH - 1) % DEPTH;
    span   = hist_time[newest] - hist_time[oldest];
    if (span == '0) return '0;
    span_l = span;
    dtemp  = longint'(hist_temp[newest]) - longint'(hist_temp[oldest]);
    q      = (dtemp * 60000) / span_l;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[RATE_W-1:0];
  endfunction

  // Apply one word to the mirror and return the sample it should produce
  function automatic roast_sample_t take_reading(logic [IN_DATA_W-1:0] w);
    roast_sample_t     s;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] gap;
    int                bt;
    int                et;
    now = w[57:26];
    gap = now - last_take_ms;
    s   = '0;
    bt  = 0;
    et  = 0;
    if (gap >= TIME_W'(cfg_interval)) begin
      s.accepted   = 1'b1;
      last_take_ms = now;
      bt = int'(w[11:0]);
      et = int'(w[24:13]);
      if (w[12] && w[25]) begin
        s.both_ok = 1'b1;
        bt += cfg_bean_ofs;
        et += cfg_env_ofs;
        hist_temp[hist_wr] = bt;
        hist_time[hist_wr] = now;
        hist_wr = (hist_wr + 1) % DEPTH;
        if (hist_fill < DEPTH) hist_fill++;
      end
    end
    s.bean_temp = bt[TEMP_W-1:0];
    s.env_temp  = et[TEMP_W-1:0];
    s.rise_rate = window_rate();
    return s;
  endfunction

  task automatic flag_fault(input string msg);
    fault_cnt++;
    if (fault_cnt <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) flag_fault($sformatf("%s: expected %0d, got %0d", name, want, got));
  endtask

  // Drive the input stream: hold each word until taken, predict on acceptance
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) sample_q.push_back(take_reading(s_axis_tdata));
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (reading_q.size() > 0 && (no_gaps || $urandom_range(99) >= 38)) begin
        s_axis_tdata  <= IN_DATA_W'(reading_q.pop_front());
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Check each result word against the oldest predicted sample
  always @(posedge clk_i) begin
    roast_sample_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (sample_q.size() == 0) begin
        flag_fault($sformatf("unexpected result word %h", m_axis_tdata));
      end else begin
        want = sample_q.pop_front();
        compare_field("accepted", int'(want.accepted), int'(m_axis_tdata[0]));
        compare_field("both_ok", int'(want.both_ok), int'(m_axis_tdata[1]));
        compare_field("bean_temp", int'(want.bean_temp), int'($signed(m_axis_tdata[15:2])));
        compare_field("env_temp", int'(want.env_temp), int'($signed(m_axis_tdata[29:16])));
        compare_field("rise_rate", int'(want.rise_rate), int'($signed(m_axis_tdata[45:30])));
      end
    end
    m_axis_tready <= rst_ni && (no_gaps || $urandom_range(99) >= 38);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic add_reading(input int bean, input bit bok, input int env, input bit eok,
                             input logic [TIME_W-1:0] now);
    reading_t r;
    r.bean_raw = bean[RAW_W-1:0];
    r.bean_ok  = bok;
    r.env_raw  = env[RAW_W-1:0];
    r.env_ok   = eok;
    r.now_ms   = now;
    reading_q.push_back(r);
  endtask

  // Hold off until the block is idle, then let it settle
  task automatic drain(input int unsigned settle);
    while (reading_q.size() > 0 || s_axis_tvalid || sample_q.size() > 0) @(negedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_IDX_READ_INTERVAL: cfg_interval = val;
      CFG_IDX_BEAN_OFFSET:   cfg_bean_ofs = int'($signed(val[OFFSET_W-1:0]));
      CFG_IDX_ENV_OFFSET:    cfg_env_ofs  = int'($signed(val[OFFSET_W-1:0]));
      default: ;
    endcase
  endtask

  // Write all registers; offsets carry junk in the unused upper bits
  task automatic setup_phase(input int interval, input int bean_ofs, input int env_ofs);
    logic [CFG_DATA_W-1:0] w;
    write_reg(CFG_IDX_READ_INTERVAL, interval[CFG_DATA_W-1:0]);
    w = CFG_DATA_W'($urandom);
    w[OFFSET_W-1:0] = bean_ofs[OFFSET_W-1:0];
    write_reg(CFG_IDX_BEAN_OFFSET, w);
    w = CFG_DATA_W'($urandom);
    w[OFFSET_W-1:0] = env_ofs[OFFSET_W-1:0];
    write_reg(CFG_IDX_ENV_OFFSET, w);
    write_reg(CFG_IDX_UNUSED, CFG_DATA_W'($urandom));
  endtask

  // Mostly paced readings with a drifting or random bean value, plus early, bunched and
  // jumping times and open thermocouples
  task automatic queue_random_phase(input int count);
    int pick;
    int step;
    int bean;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        stamp_ms += TIME_W'(cfg_interval) + $urandom_range(300);
      end else if (pick < 85) begin
        stamp_ms += $urandom_range(int'(cfg_interval));
      end else if (pick < 95) begin
        stamp_ms += $urandom_range(3);
      end else begin
        stamp_ms = $urandom;
      end
      if ($urandom_range(1)) begin
        step = $urandom_range(80);
        walk_temp = walk_temp + step - 40;
        if (walk_temp < 0) walk_temp = 0;
        if (walk_temp > 4095) walk_temp = 4095;
        bean = walk_temp;
      end else begin
        bean = $urandom_range(4095);
      end
      add_reading(bean, $urandom_range(99) < 90, $urandom_range(4095),
                  $urandom_range(99) < 90, stamp_ms);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: first reading too early, too soon, wrap to a zero span,
    // open thermocouples, negative saturation and truncation
    add_reading(5, 1, 7, 1, 32'd100);
    add_reading(4095, 1, 4095, 1, 32'd250);
    add_reading(100, 1, 100, 1, 32'd300);
    add_reading(4095, 1, 4095, 1, 32'h8000_00FA);
    add_reading(2000, 1, 2000, 1, 32'h0000_00FA);
    add_reading(1234, 0, 2222, 1, 32'd500);
    add_reading(3333, 1, 111, 0, 32'd750);
    add_reading(0, 1, 0, 1, 32'd1000);
    add_reading(3000, 1, 1000, 1, 32'd40000);
    add_reading(0, 1, 4095, 1, 32'hFFFF_FFFF);
    drain(SETTLE_CYC);

    // Zero interval, widest offsets: same time, wrap, positive saturation
    setup_phase(0, 255, -256);
    add_reading(4095, 1, 0, 1, 32'hFFFF_FFFF);
    add_reading(4095, 1, 4095, 1, 32'h0000_0100);
    add_reading(0, 1, 4095, 0, 32'h0000_0100);
    drain(SETTLE_CYC);

    stamp_ms = 32'h0000_1000;
    setup_phase(250, 0, 0);
    queue_random_phase(250);
    drain(SETTLE_CYC);

    setup_phase(0, -200, 200);
    queue_random_phase(250);
    drain(SETTLE_CYC);

    setup_phase(65535, 200, -200);
    queue_random_phase(250);
    drain(SETTLE_CYC);

    stamp_ms = $urandom;
    setup_phase(5, $urandom_range(400) - 200, $urandom_range(400) - 200);
    queue_random_phase(250);
    drain(SETTLE_CYC);

    setup_phase(1000, -256, 255);
    queue_random_phase(250);
    drain(SETTLE_CYC);

    // Run one phase with both sides streaming at full rate
    no_gaps = 1'b1;
    setup_phase($urandom_range(2000), $urandom_range(400) - 200, $urandom_range(400) - 200);
    queue_random_phase(250);
    drain(SETTLE_CYC);
    no_gaps = 1'b0;

    setup_phase(100, 0, 0);
    queue_random_phase(250);
    drain(SETTLE_CYC);

    if (sample_q.size() > 0) flag_fault($sformatf("%0d results missing", sample_q.size()));
    if (fault_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
